// File: rtl/dtpd_pkg.sv
// Shared types and default sizes for the difference turning point detector.
// No dependencies; imported by every module of the block.
`default_nettype none

package dtpd_pkg;

  // Default field sizes; the difference is always one bit wider than a sample.
  localparam int unsigned SampleWidthDef = 16;
  localparam int unsigned IndexWidthDef  = 32;

  // Direction of a pair of successive differences. Neither bit set means same.
  typedef struct packed {
    logic rise;
    logic fall;
  } dir_t;

endpackage

`default_nettype wire

// File: rtl/dtpd_dir_cmp.sv
// Direction compare between the previous and the current first difference.
// Depends on dtpd_pkg for the direction struct.
`default_nettype none

module dtpd_dir_cmp
  import dtpd_pkg::*;
#(
  parameter int unsigned DIFF_WIDTH = SampleWidthDef + 1
) (
  input  logic signed [DIFF_WIDTH-1:0] prev_diff_i,
  input  logic signed [DIFF_WIDTH-1:0] cur_diff_i,
  output dir_t                         dir_o
);

  // The sign tests on the current difference collapse into a plain ordering:
  // a negative previous value is always below a positive current one, and a
  // positive previous value is always above a non-positive current one.
  assign dir_o.rise = (prev_diff_i < cur_diff_i);
  assign dir_o.fall = (prev_diff_i > cur_diff_i);

endmodule

`default_nettype wire

// File: rtl/difference_turning_point_detector_core.sv
// Top level of the difference turning point detector: input register,
// step tracking state and result register. Depends on dtpd_pkg, dtpd_dir_cmp.
//
//   channel | handshake              | payload
//   --------+------------------------+-----------------------------------------
//   input   | in_valid_i/in_stall_o  | sample_i
//   result  | out_valid_o/out_stall_i| point_index_o, point_difference_o,
//           |                        | is_crest_o
//
// One item is taken per cycle while in_stall_o is low. A result is registered:
// the item sits in the input register, and the difference and compare path
// then loads the result register. Reset clears valid flags, tracking state
// and the sample counter, not the payload registers. A stalled result holds
// the input register, which stalls the input only while it holds an item.
`default_nettype none

module difference_turning_point_detector_core
  import dtpd_pkg::*;
#(
  parameter int unsigned SAMPLE_WIDTH = SampleWidthDef,
  parameter int unsigned INDEX_WIDTH  = IndexWidthDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [INDEX_WIDTH-1:0]         point_index_o,
  output logic signed [SAMPLE_WIDTH:0]   point_difference_o,
  output logic                           is_crest_o
);

  localparam int unsigned DiffWidth = SAMPLE_WIDTH + 1;

  // Input register.
  logic                           in_valid_q;
  logic signed [SAMPLE_WIDTH-1:0] sample_q;

  // Tracking state.
  logic                           have_sample_q, have_diff_q, have_step_q;
  logic signed [SAMPLE_WIDTH-1:0] last_sample_q;
  logic signed [DiffWidth-1:0]    last_diff_q;
  logic [INDEX_WIDTH-1:0]         step_index_q;
  logic signed [DiffWidth-1:0]    step_diff_q;
  logic                           step_rise_q;
  logic [INDEX_WIDTH-1:0]         sample_count_q;

  // Result register.
  logic                           out_valid_q;
  logic [INDEX_WIDTH-1:0]         point_index_q;
  logic signed [DiffWidth-1:0]    point_diff_q;
  logic                           is_crest_q;

  logic                           out_hold;
  logic                           proc_fire;
  logic signed [DiffWidth-1:0]    cur_diff;
  dir_t                           dir;
  logic                           new_step;
  logic                           emit;

  assign out_hold   = out_valid_q & out_stall_i;
  assign in_stall_o = in_valid_q & out_hold;
  assign proc_fire  = in_valid_q & ~out_hold;

  assign cur_diff = {sample_q[SAMPLE_WIDTH-1], sample_q}
                  - {last_sample_q[SAMPLE_WIDTH-1], last_sample_q};

  dtpd_dir_cmp #(
    .DIFF_WIDTH (DiffWidth)
  ) u_dir_cmp (
    .prev_diff_i (last_diff_q),
    .cur_diff_i  (cur_diff),
    .dir_o       (dir)
  );

  assign new_step = have_sample_q & have_diff_q & (dir.rise | dir.fall);
  // A turning point needs a recorded step whose direction the new step reverses.
  assign emit     = new_step & have_step_q & (step_rise_q != dir.rise);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q     <= 1'b0;
      have_sample_q  <= 1'b0;
      have_diff_q    <= 1'b0;
      have_step_q    <= 1'b0;
      last_sample_q  <= '0;
      last_diff_q    <= '0;
      step_index_q   <= '0;
      step_diff_q    <= '0;
      step_rise_q    <= 1'b0;
      sample_count_q <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      if (!in_stall_o) begin
        in_valid_q <= in_valid_i;
      end
      if (proc_fire) begin
        if (have_sample_q) begin
          last_diff_q <= cur_diff;
          have_diff_q <= 1'b1;
        end
        if (new_step) begin
          have_step_q  <= 1'b1;
          step_index_q <= sample_count_q;
          step_diff_q  <= cur_diff;
          step_rise_q  <= dir.rise;
        end
        last_sample_q  <= sample_q;
        have_sample_q  <= 1'b1;
        sample_count_q <= sample_count_q + 1'b1;
      end
      if (!out_hold) begin
        out_valid_q <= proc_fire & emit;
      end
    end
  end

  // Payload registers without reset.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      sample_q <= sample_i;
    end
    if (proc_fire && emit) begin
      point_index_q <= step_index_q;
      point_diff_q  <= step_diff_q;
      is_crest_q    <= step_rise_q;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign point_index_o      = point_index_q;
  assign point_difference_o = point_diff_q;
  assign is_crest_o         = is_crest_q;

endmodule

`default_nettype wire

// File: rtl/dtpd_checker.sv
// Port-level checker for the difference turning point detector, bound to the
// top level. Depends on dtpd_pkg and difference_turning_point_detector_core.
`default_nettype none

module dtpd_checker
  import dtpd_pkg::*;
#(
  parameter int unsigned SAMPLE_WIDTH = SampleWidthDef,
  parameter int unsigned INDEX_WIDTH  = IndexWidthDef
) (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_stall_o,
  input logic                           out_valid_o,
  input logic                           out_stall_i,
  input logic [INDEX_WIDTH-1:0]         point_index_o,
  input logic signed [SAMPLE_WIDTH:0]   point_difference_o,
  input logic                           is_crest_o
);

  localparam logic [1:0] MinItems = 2'd3;

  logic       in_acc, out_acc;
  logic [1:0] seen_q;
  logic       have_prev_q;
  logic       prev_crest_q;

  assign in_acc  = in_valid_i & ~in_stall_o;
  assign out_acc = out_valid_o & ~out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q       <= '0;
      have_prev_q  <= 1'b0;
      prev_crest_q <= 1'b0;
    end else begin
      if (in_acc && seen_q != MinItems) begin
        seen_q <= seen_q + 1'b1;
      end
      if (out_acc) begin
        have_prev_q  <= 1'b1;
        prev_crest_q <= is_crest_o;
      end
    end
  end

  // A turning point needs four samples; this checks that at least three were taken.
  a_no_early_point: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> seen_q == MinItems)
    else $error("result shown before three items were taken");

  // Crests and troughs must alternate.
  a_alternate: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && have_prev_q) |-> is_crest_o != prev_crest_q)
    else $error("two successive points of the same kind");

  a_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o)
    else $error("result valid dropped while stalled");

  a_payload_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> ($stable(point_index_o)
      && $stable(point_difference_o) && $stable(is_crest_o)))
    else $error("result payload changed while stalled");

endmodule

bind difference_turning_point_detector_core dtpd_checker #(
  .SAMPLE_WIDTH (SAMPLE_WIDTH),
  .INDEX_WIDTH  (INDEX_WIDTH)
) u_dtpd_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .in_valid_i         (in_valid_i),
  .in_stall_o         (in_stall_o),
  .out_valid_o        (out_valid_o),
  .out_stall_i        (out_stall_i),
  .point_index_o      (point_index_o),
  .point_difference_o (point_difference_o),
  .is_crest_o         (is_crest_o)
);

`default_nettype wire
